// ----- design/itora_pkg.sv -----
// shared types, constants and helpers for the integer to radix text unit
`default_nettype none

package itora_pkg;

    // data widths
    localparam int InWidth    = 32;
    localparam int ValueWidth = 32;
    localparam int CountWidth = $clog2(ValueWidth + 1);
    localparam int IdxWidth   = $clog2(ValueWidth);
    localparam int CharWidth  = 7;
    localparam int DigitWidth = 4;
    localparam int BaseWidth  = 5;

    // long division: bits retired per cycle and division steps per digit
    localparam int DivBits    = 8;
    localparam int DivSteps   = (ValueWidth + DivBits - 1) / DivBits;
    localparam int QuotWidth  = DivSteps * DivBits;
    localparam int StepWidth  = (DivSteps > 1) ? $clog2(DivSteps) : 1;

    // configuration port
    localparam int CfgIdxWidth  = 2;
    localparam int CfgDataWidth = 5;
    localparam logic [CfgIdxWidth-1:0] CfgRadix        = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CfgUnsignedMode = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CfgLowercase    = 2'd2;

    localparam logic [BaseWidth-1:0] RadixReset = 5'd10;
    localparam logic [BaseWidth-1:0] RadixMin   = 5'd2;
    localparam logic [BaseWidth-1:0] RadixMax   = 5'd16;

    // character codes
    localparam logic [CharWidth-1:0] CharZero  = 7'h30;
    localparam logic [CharWidth-1:0] CharLowA  = 7'h61;
    localparam logic [CharWidth-1:0] CharUpA   = 7'h41;
    localparam logic [CharWidth-1:0] CharMinus = 7'h2d;

    // queue between front and back (depth a power of two)
    localparam int QueueDepth = 2;
    localparam int QPtrWidth  = $clog2(QueueDepth);
    localparam int QCntWidth  = $clog2(QueueDepth + 1);

    // one classified conversion job
    typedef struct packed {
        logic [ValueWidth-1:0] magnitude;
        logic                  negative;
        logic [BaseWidth-1:0]  base;
        logic                  lower;
    } job_t;

    // digit value to its character
    function automatic logic [CharWidth-1:0] digit_char(input logic [DigitWidth-1:0] d,
                                                        input logic lower);
        logic [CharWidth-1:0] d7;
        d7 = {{(CharWidth - DigitWidth){1'b0}}, d};
        if (d < 4'd10) begin
            digit_char = CharZero + d7;
        end else if (lower) begin
            digit_char = CharLowA + d7 - 7'd10;
        end else begin
            digit_char = CharUpA + d7 - 7'd10;
        end
    endfunction

endpackage

`default_nettype wire

// ----- design/itora_front.sv -----
// front end: configuration registers and classification of each input value
`default_nettype none

module itora_front import itora_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_we,
    input  wire logic [CfgIdxWidth-1:0]  cfg_index,
    input  wire logic [CfgDataWidth-1:0] cfg_data,
    input  wire logic [InWidth-1:0]      s_value,
    output job_t                         job
);

    logic [BaseWidth-1:0] radix_reg;
    logic                 unsigned_reg;
    logic                 lower_reg;
    logic [63:0]          ext;
    logic [ValueWidth-1:0] bits;
    logic                 neg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg    <= RadixReset;
            unsigned_reg <= 1'b0;
            lower_reg    <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CfgRadix:        radix_reg    <= cfg_data;
                CfgUnsignedMode: unsigned_reg <= cfg_data[0];
                CfgLowercase:    lower_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // narrow, take magnitude and clamp the base
    always_comb begin
        ext  = {{(64 - InWidth){s_value[InWidth-1]}}, s_value};
        bits = ext[ValueWidth-1:0];
        neg  = !unsigned_reg && bits[ValueWidth-1];
        job.negative  = neg;
        job.magnitude = neg ? (~bits + 1'b1) : bits;
        if (radix_reg < RadixMin) begin
            job.base = RadixMin;
        end else if (radix_reg > RadixMax) begin
            job.base = RadixMax;
        end else begin
            job.base = radix_reg;
        end
        job.lower = lower_reg;
    end

endmodule

`default_nettype wire

// ----- design/itora_fifo.sv -----
// short job queue between front and back
`default_nettype none

module itora_fifo import itora_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  job_t      wr_job,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output job_t      rd_job
);

    job_t                 entry_reg [QueueDepth];
    logic [QPtrWidth-1:0] wr_ptr_reg;
    logic [QPtrWidth-1:0] rd_ptr_reg;
    logic [QCntWidth-1:0] count_reg;
    logic                 push;
    logic                 pop;

    assign wr_ready = (count_reg != QCntWidth'(QueueDepth));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

`default_nettype wire

// ----- design/itora_back.sv -----
// back end: digit extraction by long division, digit store, reverse emission
`default_nettype none

module itora_back import itora_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 job_valid,
    output logic                      job_ready,
    input  job_t                      job,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [CharWidth-1:0]      m_character,
    output logic                      m_last_char
);

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StDiv  = 3'd1;
    localparam logic [2:0] StSign = 3'd2;
    localparam logic [2:0] StRead = 3'd3;
    localparam logic [2:0] StEmit = 3'd4;

    logic [2:0]            state_reg;
    logic [QuotWidth-1:0]  quot_reg;
    logic [DigitWidth-1:0] rem_reg;
    logic [StepWidth-1:0]  step_reg;
    logic [CountWidth-1:0] count_reg;
    logic                  neg_reg;
    logic [BaseWidth-1:0]  base_reg;
    logic                  lower_reg;
    logic [DigitWidth-1:0] rd_data_reg;
    logic [DigitWidth-1:0] digit_mem [ValueWidth];

    logic                  m_valid_reg;
    logic [CharWidth-1:0]  m_char_reg;
    logic                  m_last_reg;

    logic [BaseWidth-1:0]        part;
    logic [DivBits-1:0]          qbits;
    logic [QuotWidth+DivBits-1:0] shifted;
    logic [QuotWidth-1:0]        div_quot;
    logic [DigitWidth-1:0]       div_rem;
    logic                        out_free;
    logic                        out_load;
    logic                        last_step;
    logic                        mem_we;
    logic [IdxWidth-1:0]         rd_addr;

    assign job_ready   = (state_reg == StIdle);
    assign out_free    = !m_valid_reg || m_ready;
    assign out_load    = out_free && ((state_reg == StSign) || (state_reg == StEmit));
    assign last_step   = (step_reg == StepWidth'(DivSteps - 1));
    assign mem_we      = (state_reg == StDiv) && last_step;
    assign rd_addr     = count_reg[IdxWidth-1:0] - 1'b1;
    assign m_valid     = m_valid_reg;
    assign m_character = m_char_reg;
    assign m_last_char = m_last_reg;

    // eight restoring division steps on the top bits of the quotient
    always_comb begin
        part = {1'b0, rem_reg};
        for (int k = 0; k < DivBits; k++) begin
            part = {part[DigitWidth-1:0], quot_reg[QuotWidth-1-k]};
            if (part >= base_reg) begin
                part = part - base_reg;
                qbits[DivBits-1-k] = 1'b1;
            end else begin
                qbits[DivBits-1-k] = 1'b0;
            end
        end
        shifted  = {quot_reg, qbits};
        div_quot = shifted[QuotWidth-1:0];
        div_rem  = part[DigitWidth-1:0];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= StIdle;
            quot_reg    <= '0;
            rem_reg     <= '0;
            step_reg    <= '0;
            count_reg   <= '0;
            neg_reg     <= 1'b0;
            base_reg    <= RadixReset;
            lower_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // output register: load a new character or drop after acceptance
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                StIdle: begin
                    if (job_valid) begin
                        quot_reg  <= QuotWidth'(job.magnitude);
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        count_reg <= '0;
                        neg_reg   <= job.negative;
                        base_reg  <= job.base;
                        lower_reg <= job.lower;
                        state_reg <= StDiv;
                    end
                end
                StDiv: begin
                    quot_reg <= div_quot;
                    if (last_step) begin
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        count_reg <= count_reg + 1'b1;
                        if (div_quot == '0) begin
                            state_reg <= neg_reg ? StSign : StRead;
                        end
                    end else begin
                        rem_reg  <= div_rem;
                        step_reg <= step_reg + 1'b1;
                    end
                end
                StSign: begin
                    if (out_free) begin
                        m_char_reg  <= CharMinus;
                        m_last_reg  <= 1'b0;
                        state_reg   <= StRead;
                    end
                end
                StRead: begin
                    state_reg <= StEmit;
                end
                StEmit: begin
                    if (out_free) begin
                        m_char_reg  <= digit_char(rd_data_reg, lower_reg);
                        m_last_reg  <= (count_reg == CountWidth'(1));
                        count_reg   <= count_reg - 1'b1;
                        state_reg   <= (count_reg == CountWidth'(1)) ? StIdle : StRead;
                    end
                end
                default: begin
                    state_reg <= StIdle;
                end
            endcase
        end
    end

    // digit store: written once per digit, read with a registered port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            digit_mem[count_reg[IdxWidth-1:0]] <= div_rem;
        end
        if (state_reg == StRead) begin
            rd_data_reg <= digit_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/integer_to_radix_ascii_unit.sv -----
// top level of the integer to radix ascii text converter
`default_nettype none

// Converts one 32-bit integer per input transaction into its text in base 2
// to 16 (register 0, clamped to that range), one ASCII character per output
// transaction, most significant first, with m_last_char on the final one.
// Register 1 selects unsigned reading (no minus sign), register 2 lower-case
// hex letters. The front classifies a value in the cycle it is accepted and
// parks it in a two-entry queue, so up to two values are taken while the
// back is busy. The back finds digits by long division retiring eight bits
// per cycle, one pass of division steps over the whole value per digit.
// A minus sign, if any, is then loaded, and each digit goes through a
// digit store read and an output register load, waiting while the sink
// is not ready. The back takes a new value only after the last character
// of the previous one is loaded.
module integer_to_radix_ascii_unit import itora_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_we,
    input  wire logic [CfgIdxWidth-1:0]  cfg_index,
    input  wire logic [CfgDataWidth-1:0] cfg_data,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [InWidth-1:0]      s_value,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [CharWidth-1:0]         m_character,
    output logic                         m_last_char
);

    job_t front_job;
    job_t queue_job;
    logic queue_valid;
    logic back_ready;

    // classification and configuration
    itora_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_value   (s_value),
        .job       (front_job)
    );

    // decoupling queue
    itora_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_job   (front_job),
        .rd_valid (queue_valid),
        .rd_ready (back_ready),
        .rd_job   (queue_job)
    );

    // conversion and emission
    itora_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (queue_valid),
        .job_ready   (back_ready),
        .job         (queue_job),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last_char (m_last_char)
    );

endmodule

`default_nettype wire

// ----- tb/itora_checker.sv -----
// checker for the integer to radix ascii unit: predicts each value's text and compares characters
module itora_checker import itora_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [InWidth-1:0]      s_value,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [CharWidth-1:0]    m_character,
    input  logic                    m_last_char,
    output int                      fail_count,
    output int                      pending_chars,
    output int                      values_seen,
    output int                      chars_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [CharWidth-1:0] code;
        logic                 last;
    } text_char_t;

    // characters still owed by the unit, oldest first
    text_char_t expected_chars[$];

    // shadow copy of the configuration registers
    logic [BaseWidth-1:0] radix_reg;
    logic                 unsigned_reg;
    logic                 lower_reg;

    // queue the text of one accepted value
    task automatic predict_text(input logic [InWidth-1:0] value);
        logic [63:0]           mask;
        logic [63:0]           bits;
        logic [63:0]           quotient;
        logic [DigitWidth-1:0] digits [64];
        int                    base;
        int                    count;
        logic                  negative;
        string                 letters;
        text_char_t            entry;
        mask = (64'd1 << ValueWidth) - 64'd1;
        bits = {{(64 - InWidth){value[InWidth-1]}}, value} & mask;
        // out-of-range base codes clamp to the nearest legal base
        base = int'(radix_reg);
        if (radix_reg < RadixMin) base = int'(RadixMin);
        if (radix_reg > RadixMax) base = int'(RadixMax);
        letters = lower_reg ? "0123456789abcdef" : "0123456789ABCDEF";
        negative = !unsigned_reg && bits[ValueWidth-1];
        // magnitude wraps at the value width, so the most negative value stays exact
        quotient = negative ? ((~bits + 64'd1) & mask) : bits;
        count = 0;
        do begin
            digits[count] = DigitWidth'(quotient % base);
            count++;
            quotient = quotient / base;
        end while (quotient != 0);
        if (negative) begin
            entry.code = CharMinus;
            entry.last = 1'b0;
            expected_chars.push_back(entry);
        end
        // most significant digit first
        for (int i = count - 1; i >= 0; i--) begin
            entry.code = CharWidth'(letters[digits[i]]);
            entry.last = (i == 0);
            expected_chars.push_back(entry);
        end
    endtask

    task automatic flag_failure(input string what);
        fail_count++;
        if (fail_count <= 10) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // watch both channels and the register port at each rising edge
    always @(posedge aclk) begin : watch
        text_char_t want;
        if (!aresetn) begin
            radix_reg    = RadixReset;
            unsigned_reg = 1'b0;
            lower_reg    = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_text(s_value);
                values_seen++;
            end
            if (m_valid && m_ready) begin
                chars_seen++;
                if (expected_chars.size() == 0) begin
                    flag_failure($sformatf("unexpected character 0x%02h last=%0b",
                                           m_character, m_last_char));
                end else begin
                    want = expected_chars.pop_front();
                    if (m_character !== want.code || m_last_char !== want.last)
                        flag_failure($sformatf(
                            "character %0d: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                            chars_seen, want.code, want.last, m_character, m_last_char));
                end
            end
            // register writes; an index beyond the list is dropped
            if (cfg_we) begin
                case (cfg_index)
                    CfgRadix:        radix_reg    = cfg_data;
                    CfgUnsignedMode: unsigned_reg = cfg_data[0];
                    CfgLowercase:    lower_reg    = cfg_data[0];
                    default: ;
                endcase
            end
        end
        pending_chars = expected_chars.size();
    end

endmodule

// ----- tb/testbench.sv -----
// top of the integer to radix ascii testbench: clock, reset, stimulus and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import itora_pkg::*;

    localparam int LongHoldCycles = 400;
    localparam int PhaseCount     = 10;
    localparam int StreamItems    = 30;
    localparam logic [CfgIdxWidth-1:0] CfgUnusedIndex = 2'd3;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_we;
    logic [CfgIdxWidth-1:0]  cfg_index;
    logic [CfgDataWidth-1:0] cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic [InWidth-1:0]      s_value;
    logic                    m_valid;
    logic                    m_ready;
    logic [CharWidth-1:0]    m_character;
    logic                    m_last_char;

    int fail_count;
    int pending_chars;
    int values_seen;
    int chars_seen;
    int settings_used;
    bit idling_on;
    bit hold_request;

    integer_to_radix_ascii_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last_char (m_last_char)
    );

    itora_checker text_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_character   (m_character),
        .m_last_char   (m_last_char),
        .fail_count    (fail_count),
        .pending_chars (pending_chars),
        .values_seen   (values_seen),
        .chars_seen    (chars_seen)
    );

    // 8 ns clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // hard limit on run length
    initial begin
        #5_000_000;
        $display("timeout with %0d characters outstanding", pending_chars);
        $display("** integer_to_radix_ascii_unit: FAILED **");
        $finish;
    end

    // character sink: random short stalls, one long hold-off on request
    initial begin : sink
        int stall_left;
        m_ready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (LongHoldCycles) @(negedge aclk);
                hold_request = 1'b0;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (idling_on && $urandom_range(0, 99) < 7) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(0, 4);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // offer one value and hold it until the unit takes it
    task automatic send_value(input logic [InWidth-1:0] value);
        if (idling_on && $urandom_range(0, 99) < 7) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // stop offering and let every owed character drain out
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_chars != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    // write all three registers, optionally followed by a write to the unused index
    task automatic apply_settings(input int radix, input bit unsigned_read, input bit lower,
                                  input bit poke_unused);
        logic [CfgDataWidth-1:0] junk;
        junk = CfgDataWidth'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= CfgRadix;
        cfg_data  <= CfgDataWidth'(radix);
        @(negedge aclk);
        junk[0] = unsigned_read;
        cfg_index <= CfgUnsignedMode;
        cfg_data  <= junk;
        @(negedge aclk);
        junk = CfgDataWidth'($urandom);
        junk[0] = lower;
        cfg_index <= CfgLowercase;
        cfg_data  <= junk;
        @(negedge aclk);
        if (poke_unused) begin
            cfg_index <= CfgUnusedIndex;
            cfg_data  <= CfgDataWidth'($urandom);
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin : stimulus
        logic [InWidth-1:0] value;
        int                 radix;
        int                 pick;
        cfg_we = 1'b0;
        cfg_index = CfgRadix;
        cfg_data = '0;
        s_valid = 1'b0;
        s_value = '0;
        aresetn = 1'b0;
        idling_on = 1'b1;
        hold_request = 1'b0;
        settings_used = 1;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: decimal, signed, upper case
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd1000000000);
        send_value(32'hFFFF_FFF6);

        // hex, lower case, signed
        wait_drained();
        apply_settings(16, 1'b0, 1'b1, 1'b1);
        send_value(32'hDEAD_BEEF);
        send_value(32'h00AB_CDEF);
        send_value(32'h8000_0000);

        // hex, upper case, unsigned
        wait_drained();
        apply_settings(16, 1'b1, 1'b0, 1'b0);
        send_value(32'hFFFF_FFFF);
        send_value(32'hFEDC_BA98);
        send_value(32'h0000_000F);

        // binary: longest texts, with and without a sign
        wait_drained();
        apply_settings(2, 1'b1, 1'b1, 1'b0);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd0);
        wait_drained();
        apply_settings(2, 1'b0, 1'b0, 1'b0);
        send_value(32'h8000_0000);
        send_value(32'h5555_5555);

        // base codes below two and above sixteen clamp
        wait_drained();
        apply_settings(0, 1'b0, 1'b0, 1'b0);
        send_value(32'd5);
        wait_drained();
        apply_settings(1, 1'b0, 1'b0, 1'b0);
        send_value(32'hFFFF_FFFA);
        wait_drained();
        apply_settings(31, 1'b1, 1'b1, 1'b0);
        send_value(32'd255);
        wait_drained();
        apply_settings(17, 1'b0, 1'b0, 1'b1);
        send_value(32'hFFFF_FF01);

        // odd bases
        wait_drained();
        apply_settings(3, 1'b0, 1'b0, 1'b0);
        send_value(32'h8000_0000);
        wait_drained();
        apply_settings(7, 1'b1, 1'b0, 1'b0);
        send_value(32'hFFFF_FFFF);

        // random phases, each with its own register settings
        for (int phase = 0; phase < PhaseCount; phase++) begin
            wait_drained();
            case (phase)
                0:       radix = 2;
                1:       radix = 16;
                2:       radix = 10;
                3:       radix = $urandom_range(0, 1);
                4:       radix = $urandom_range(17, 31);
                default: radix = $urandom_range(2, 16);
            endcase
            apply_settings(radix, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           phase == 7);
            // two phases run with no idling on either side
            idling_on = !(phase == 5 || phase == 6);
            // sink holds off while values keep coming, so the unit backs up
            if (phase == 2) hold_request = 1'b1;
            for (int n = 0; n < StreamItems; n++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        pick = $urandom_range(0, 4);
                        case (pick)
                            0:       value = 32'd0;
                            1:       value = 32'h7FFF_FFFF;
                            2:       value = 32'h8000_0000;
                            3:       value = 32'hFFFF_FFFF;
                            default: value = 32'd1;
                        endcase
                    end
                    1, 2:    value = $urandom_range(0, 300);
                    3, 4:    value = $urandom >> $urandom_range(0, 31);
                    default: value = $urandom;
                endcase
                if ($urandom_range(0, 3) == 0) value = -value;
                send_value(value);
            end
        end

        wait_drained();
        repeat (20) @(negedge aclk);

        $display("converted %0d values into %0d characters under %0d register settings",
                 values_seen, chars_seen, settings_used);
        $display("covered bases 2 to 16, clamped base codes, signed and unsigned, both cases");
        if (fail_count == 0) begin
            $display("** integer_to_radix_ascii_unit: PASSED **");
        end else begin
            $display("%0d mismatching characters", fail_count);
            $display("** integer_to_radix_ascii_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/itora_pkg.sv
design/itora_front.sv
design/itora_fifo.sv
design/itora_back.sv
design/integer_to_radix_ascii_unit.sv
tb/itora_checker.sv
tb/testbench.sv
